// ===== hw/rtl/m68000_instruction_decoder_defines.svh =====
// assertion macros for the instruction decoder
`ifndef M68000_INSTRUCTION_DECODER_DEFINES_SVH
`define M68000_INSTRUCTION_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DEC_ASSERT_NOW(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("decoder check failed");
`define DEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder sequence check failed");
`else
`define DEC_ASSERT_NOW(lbl, cond)
`define DEC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/m68k_dec_pkg.sv =====
package m68k_dec_pkg;

    typedef struct packed {
        logic [31:0] instr_address;
        logic [15:0] word_zero;
        logic [15:0] word_one;
        logic [15:0] word_two;
        logic [15:0] word_three;
        logic [15:0] word_four;
    } dec_in_t;

    typedef struct packed {
        logic [6:0]  op_kind;
        logic [2:0]  op_size;
        logic [27:0] src_desc;
        logic [31:0] src_value;
        logic [27:0] dst_desc;
        logic [31:0] dst_value;
        logic [31:0] imm_value;
        logic [31:0] branch_target;
        logic [6:0]  reg_and_cond;
        logic [8:0]  flag_bits;
        logic [7:0]  cycle_count;
        logic [3:0]  insn_length;
    } dec_out_t;

    // operation codes
    localparam logic [6:0] K_INVALID = 7'd0,  K_ORI_CCR = 7'd1,  K_ORI_SR = 7'd2,
        K_ANDI_CCR = 7'd3, K_ANDI_SR = 7'd4, K_EORI_CCR = 7'd5, K_EORI_SR = 7'd6,
        K_MOVEP_RM = 7'd7, K_MOVEP_MR = 7'd8, K_BTST = 7'd9, K_BCHG = 7'd10,
        K_BCLR = 7'd11, K_BSET = 7'd12, K_ORI = 7'd13, K_ANDI = 7'd14, K_SUBI = 7'd15,
        K_ADDI = 7'd16, K_EORI = 7'd17, K_CMPI = 7'd18, K_MOVEA = 7'd19, K_MOVE = 7'd20,
        K_LEA = 7'd21, K_CHK = 7'd22, K_MOVE_FROM_SR = 7'd23, K_MOVE_TO_CCR = 7'd24,
        K_MOVE_TO_SR = 7'd25, K_NBCD = 7'd26, K_SWAP = 7'd27, K_PEA = 7'd28,
        K_EXT = 7'd29, K_MOVEM_RM = 7'd30, K_ILLEGAL = 7'd31, K_TAS = 7'd32,
        K_MOVEM_MR = 7'd33, K_JSR = 7'd34, K_JMP = 7'd35, K_TRAP = 7'd36,
        K_LINK = 7'd37, K_UNLK = 7'd38, K_MOVE_TO_USP = 7'd39, K_MOVE_FROM_USP = 7'd40,
        K_RESET = 7'd41, K_NOP = 7'd42, K_STOP = 7'd43, K_RTE = 7'd44, K_RTS = 7'd45,
        K_TRAPV = 7'd46, K_RTR = 7'd47, K_NEGX = 7'd48, K_CLR = 7'd49, K_NEG = 7'd50,
        K_NOT = 7'd51, K_TST = 7'd52, K_DBCC = 7'd53, K_SCC = 7'd54, K_SUBQ = 7'd55,
        K_ADDQ = 7'd56, K_BRA = 7'd57, K_BSR = 7'd58, K_BCC = 7'd59, K_MOVEQ = 7'd60,
        K_MULS = 7'd61, K_MULU = 7'd62, K_DIVS = 7'd63, K_DIVU = 7'd64, K_ABCD = 7'd65,
        K_SBCD = 7'd66, K_EXG = 7'd67, K_AND = 7'd68, K_OR = 7'd69, K_ADDA = 7'd70,
        K_SUBA = 7'd71, K_ADDX = 7'd72, K_SUBX = 7'd73, K_ADD = 7'd74, K_SUB = 7'd75,
        K_CMPA = 7'd76, K_CMPM = 7'd77, K_EOR = 7'd78, K_CMP = 7'd79, K_ASL = 7'd80,
        K_LSL = 7'd81, K_ROXL = 7'd82, K_ROL = 7'd83, K_ASR = 7'd84, K_LSR = 7'd85,
        K_ROXR = 7'd86, K_ROR = 7'd87, K_LINE_A = 7'd88, K_LINE_F = 7'd89;

    // operand modes
    localparam logic [3:0] EM_NONE = 4'd0, EM_DREG = 4'd1, EM_AREG = 4'd2, EM_IND = 4'd3,
        EM_POSTINC = 4'd4, EM_PREDEC = 4'd5, EM_DISP = 4'd6, EM_INDEX = 4'd7,
        EM_ABSW = 4'd8, EM_ABSL = 4'd9, EM_PCDISP = 4'd10, EM_PCINDEX = 4'd11,
        EM_IMM = 4'd12;

    // allowed-mode masks
    localparam logic [15:0] AM_ALL = 16'h1FFE, AM_DATA = 16'h1FFA, AM_CONTROL = 16'h0FC8,
        AM_ALTER = 16'h03FE, AM_DATA_ALT = 16'h03FA, AM_MEM_ALT = 16'h03F8,
        AM_CTRL_ALT = 16'h03C8, AM_PREDEC = 16'h0020, AM_POSTINC = 16'h0010,
        AM_DATA_NOIMM = 16'h0FFA;

    localparam logic [8:0] FL_END = 9'h001, FL_PRIV = 9'h002, FL_BRANCH = 9'h004,
        FL_NOFALL = 9'h008, FL_CALL = 9'h010, FL_INDIRECT = 9'h020, FL_RETURN = 9'h040,
        FL_COND = 9'h080, FL_OK = 9'h100;

    localparam logic [8:0] FL_INVALID = FL_BRANCH | FL_NOFALL | FL_END | FL_INDIRECT;

endpackage

// ===== hw/rtl/m68k_dec_core.sv =====
module m68k_dec_core (
    input  m68k_dec_pkg::dec_in_t  insn,
    output m68k_dec_pkg::dec_out_t res
);
    import m68k_dec_pkg::*;

    typedef struct packed {
        logic [3:0]  mode;
        logic [2:0]  rg;
        logic [3:0]  xreg;
        logic        xlong;
        logic [15:0] disp;
        logic [31:0] value;
    } ea_t;

    typedef struct packed {
        logic [6:0]  kind;
        logic [2:0]  size;
        logic [31:0] imm;
        logic [31:0] target;
        logic [2:0]  rg;
        logic [3:0]  cc;
        logic [8:0]  flags;
        logic [7:0]  cycles;
        ea_t         src;
        ea_t         dst;
        logic [3:0]  n;
    } dec_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

    // next extension word, zero past the fourth
    function automatic logic [15:0] rd_w(input logic [63:0] w, inout logic [3:0] n);
        logic [15:0] v;
        v = (n < 4'd4) ? w[{n[1:0], 4'b0000} +: 16] : 16'h0000;
        if (n < 4'd8)
        begin
            n = n + 4'd1;
        end
        return v;
    endfunction

    function automatic logic [31:0] rd_l(input logic [63:0] w, inout logic [3:0] n);
        logic [15:0] h;
        logic [15:0] l;
        h = rd_w(w, n);
        l = rd_w(w, n);
        return {h, l};
    endfunction

    function automatic logic [31:0] rd_cur(input logic [31:0] pc, input logic [3:0] n);
        return pc + 32'd2 + {27'd0, n, 1'b0};
    endfunction

    function automatic ea_t ea_reg(input logic [3:0] m, input logic [2:0] r);
        ea_t e;
        e = '0;
        e.mode = m;
        e.rg = r;
        return e;
    endfunction

    function automatic ea_t ea_imm(input logic [31:0] v);
        ea_t e;
        e = '0;
        e.mode = EM_IMM;
        e.value = v;
        return e;
    endfunction

    function automatic logic [7:0] ea_time(input logic [3:0] m, input logic lng);
        unique case (m)
            EM_IND, EM_POSTINC, EM_IMM: return lng ? 8'd8 : 8'd4;
            EM_PREDEC:                  return lng ? 8'd10 : 8'd6;
            EM_DISP, EM_ABSW, EM_PCDISP: return lng ? 8'd12 : 8'd8;
            EM_INDEX, EM_PCINDEX:       return lng ? 8'd14 : 8'd10;
            EM_ABSL:                    return lng ? 8'd16 : 8'd12;
            default:                    return 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] lea_time(input logic [3:0] m);
        unique case (m)
            EM_DISP, EM_ABSW, EM_PCDISP:    return 8'd8;
            EM_INDEX, EM_PCINDEX, EM_ABSL:  return 8'd12;
            default:                        return 8'd4;
        endcase
    endfunction

    function automatic logic [7:0] jmp_time(input logic [3:0] m);
        unique case (m)
            EM_DISP, EM_ABSW, EM_PCDISP: return 8'd10;
            EM_INDEX, EM_PCINDEX:        return 8'd14;
            EM_ABSL:                     return 8'd12;
            default:                     return 8'd8;
        endcase
    endfunction

    function automatic logic [2:0] size2(input logic [1:0] s);
        unique case (s)
            2'd0:    return 3'd1;
            2'd1:    return 3'd2;
            2'd2:    return 3'd4;
            default: return 3'd0;
        endcase
    endfunction

    function automatic logic [4:0] popcnt16(input logic [15:0] v);
        logic [4:0] c;
        c = '0;
        for (int i = 0; i < 16; i++)
        begin
            c = c + {4'd0, v[i]};
        end
        return c;
    endfunction

    function automatic logic [6:0] bit_op(input logic [1:0] s);
        unique case (s)
            2'd0:    return K_BTST;
            2'd1:    return K_BCHG;
            2'd2:    return K_BCLR;
            default: return K_BSET;
        endcase
    endfunction

    function automatic logic [6:0] imm_op(input logic [2:0] s);
        unique case (s)
            3'd0:    return K_ORI;
            3'd1:    return K_ANDI;
            3'd2:    return K_SUBI;
            3'd3:    return K_ADDI;
            3'd5:    return K_EORI;
            3'd6:    return K_CMPI;
            default: return K_INVALID;
        endcase
    endfunction

    function automatic logic [6:0] shift_op(input logic left, input logic [1:0] s);
        unique case (s)
            2'd0:    return left ? K_ASL : K_ASR;
            2'd1:    return left ? K_LSL : K_LSR;
            2'd2:    return left ? K_ROXL : K_ROXR;
            default: return left ? K_ROL : K_ROR;
        endcase
    endfunction

    function automatic logic get_ea(input logic [63:0] w, input logic [31:0] pc,
                                    inout logic [3:0] n, input logic [2:0] mode,
                                    input logic [2:0] r, input logic [2:0] size,
                                    output ea_t e, input logic [15:0] allowed);
        logic [15:0] ext;
        logic [31:0] base;
        e = '0;
        e.rg = r;
        unique case (mode)
            3'd0: e.mode = EM_DREG;
            3'd1: e.mode = EM_AREG;
            3'd2: e.mode = EM_IND;
            3'd3: e.mode = EM_POSTINC;
            3'd4: e.mode = EM_PREDEC;
            3'd5:
            begin
                e.mode = EM_DISP;
                e.disp = rd_w(w, n);
            end
            3'd6:
            begin
                e.mode = EM_INDEX;
                ext = rd_w(w, n);
                e.xreg = ext[15:12];
                e.xlong = ext[11];
                e.disp = {{8{ext[7]}}, ext[7:0]};
                if (ext[10:8] != 3'd0)
                begin
                    return 1'b0;
                end
            end
            default:
            begin
                unique case (r)
                    3'd0:
                    begin
                        e.mode = EM_ABSW;
                        e.value = sx16(rd_w(w, n));
                    end
                    3'd1:
                    begin
                        e.mode = EM_ABSL;
                        e.value = rd_l(w, n);
                    end
                    3'd2:
                    begin
                        e.mode = EM_PCDISP;
                        base = rd_cur(pc, n);
                        ext = rd_w(w, n);
                        e.disp = ext;
                        e.value = base + sx16(ext);
                    end
                    3'd3:
                    begin
                        e.mode = EM_PCINDEX;
                        base = rd_cur(pc, n);
                        ext = rd_w(w, n);
                        e.xreg = ext[15:12];
                        e.xlong = ext[11];
                        e.disp = {{8{ext[7]}}, ext[7:0]};
                        e.value = base + sx8(ext[7:0]);
                        if (ext[10:8] != 3'd0)
                        begin
                            return 1'b0;
                        end
                    end
                    3'd4:
                    begin
                        e.mode = EM_IMM;
                        if (size == 3'd1)
                        begin
                            ext = rd_w(w, n);
                            e.value = {24'd0, ext[7:0]};
                        end
                        else if (size == 3'd2)
                        begin
                            e.value = {16'd0, rd_w(w, n)};
                        end
                        else
                        begin
                            e.value = rd_l(w, n);
                        end
                    end
                    default: return 1'b0;
                endcase
            end
        endcase
        return allowed[e.mode];
    endfunction

    function automatic logic dec_insn(input dec_in_t x, inout dec_t o);
        logic [15:0] op;
        logic [63:0] w;
        logic [31:0] pc;
        logic [3:0]  hi;
        logic [2:0]  rx;
        logic [2:0]  ry;
        logic [2:0]  mode;
        logic [1:0]  sz2;
        logic [15:0] t16;
        logic [15:0] allowed;
        logic [2:0]  t3;
        logic [3:0]  tm;
        logic [4:0]  cnt;
        logic [7:0]  bc;
        logic [7:0]  per;
        logic [31:0] base;
        logic [31:0] ofs;
        logic        lng;
        logic        f;
        logic        sgn;
        logic        priv;

        op = x.word_zero;
        w = {x.word_four, x.word_three, x.word_two, x.word_one};
        pc = x.instr_address;
        hi = op[15:12];
        rx = op[11:9];
        ry = op[2:0];
        mode = op[5:3];
        sz2 = op[7:6];

        unique case (hi)
            4'h0:
            begin
                if (op == 16'h003C || op == 16'h007C || op == 16'h023C ||
                    op == 16'h027C || op == 16'h0A3C || op == 16'h0A7C)
                begin
                    priv = op[6];
                    unique case (op[11:8])
                        4'h0:    o.kind = priv ? K_ORI_SR : K_ORI_CCR;
                        4'h2:    o.kind = priv ? K_ANDI_SR : K_ANDI_CCR;
                        default: o.kind = priv ? K_EORI_SR : K_EORI_CCR;
                    endcase
                    t16 = rd_w(w, o.n);
                    o.imm = priv ? {16'd0, t16} : {24'd0, t16[7:0]};
                    o.cycles = 8'd20;
                    o.flags = o.flags | FL_END | (priv ? FL_PRIV : 9'd0);
                    return 1'b1;
                end
                if (op[8])
                begin
                    if (mode == 3'd1)
                    begin
                        o.size = sz2[0] ? 3'd4 : 3'd2;
                        o.kind = sz2[1] ? K_MOVEP_RM : K_MOVEP_MR;
                        o.rg = rx;
                        o.dst = ea_reg(EM_DISP, ry);
                        o.dst.disp = rd_w(w, o.n);
                        o.cycles = (o.size == 3'd4) ? 8'd24 : 8'd16;
                        return 1'b1;
                    end
                    o.kind = bit_op(sz2);
                    o.src = ea_reg(EM_DREG, rx);
                    if (!get_ea(w, pc, o.n, mode, ry, 3'd1, o.dst,
                                (o.kind == K_BTST) ? AM_DATA : AM_DATA_ALT))
                    begin
                        return 1'b0;
                    end
                    o.size = (o.dst.mode == EM_DREG) ? 3'd4 : 3'd1;
                    if (o.dst.mode == EM_DREG)
                    begin
                        o.cycles = (o.kind == K_BTST) ? 8'd6 :
                                   (o.kind == K_BCLR) ? 8'd10 : 8'd8;
                    end
                    else
                    begin
                        o.cycles = ((o.kind == K_BTST) ? 8'd4 : 8'd8) +
                                   ea_time(o.dst.mode, 1'b0);
                    end
                    return 1'b1;
                end
                if (rx == 3'd4)
                begin
                    o.kind = bit_op(sz2);
                    t16 = rd_w(w, o.n);
                    if (t16[15:8] != 8'd0)
                    begin
                        return 1'b0;
                    end
                    o.src = ea_imm({24'd0, t16[7:0]});
                    allowed = (o.kind == K_BTST) ? AM_DATA_NOIMM : AM_DATA_ALT;
                    if (!get_ea(w, pc, o.n, mode, ry, 3'd1, o.dst, allowed))
                    begin
                        return 1'b0;
                    end
                    o.size = (o.dst.mode == EM_DREG) ? 3'd4 : 3'd1;
                    if (o.dst.mode == EM_DREG)
                    begin
                        o.cycles = (o.kind == K_BTST) ? 8'd10 :
                                   (o.kind == K_BCLR) ? 8'd14 : 8'd12;
                    end
                    else
                    begin
                        o.cycles = ((o.kind == K_BTST) ? 8'd8 : 8'd12) +
                                   ea_time(o.dst.mode, 1'b0);
                    end
                    return 1'b1;
                end
                o.kind = imm_op(rx);
                if (o.kind == K_INVALID)
                begin
                    return 1'b0;
                end
                o.size = size2(sz2);
                if (o.size == 3'd0)
                begin
                    return 1'b0;
                end
                if (o.size == 3'd4)
                begin
                    o.src = ea_imm(rd_l(w, o.n));
                end
                else if (o.size == 3'd2)
                begin
                    o.src = ea_imm({16'd0, rd_w(w, o.n)});
                end
                else
                begin
                    t16 = rd_w(w, o.n);
                    o.src = ea_imm({24'd0, t16[7:0]});
                end
                if (!get_ea(w, pc, o.n, mode, ry, o.size, o.dst, AM_DATA_ALT))
                begin
                    return 1'b0;
                end
                lng = (o.size == 3'd4);
                if (o.kind == K_CMPI)
                begin
                    o.cycles = (o.dst.mode == EM_DREG) ? (lng ? 8'd14 : 8'd8) :
                               (lng ? 8'd12 : 8'd8) + ea_time(o.dst.mode, lng);
                end
                else
                begin
                    o.cycles = (o.dst.mode == EM_DREG) ? (lng ? 8'd16 : 8'd8) :
                               (lng ? 8'd20 : 8'd12) + ea_time(o.dst.mode, lng);
                end
                return 1'b1;
            end
            4'h1, 4'h2, 4'h3:
            begin
                o.size = (hi == 4'h1) ? 3'd1 : (hi == 4'h3) ? 3'd2 : 3'd4;
                lng = (o.size == 3'd4);
                if (!get_ea(w, pc, o.n, mode, ry, o.size, o.src,
                            (o.size == 3'd1) ? AM_DATA : AM_ALL))
                begin
                    return 1'b0;
                end
                t3 = op[8:6];
                if (t3 == 3'd1)
                begin
                    if (o.size == 3'd1)
                    begin
                        return 1'b0;
                    end
                    o.kind = K_MOVEA;
                    o.dst = ea_reg(EM_AREG, rx);
                    o.cycles = 8'd4 + ea_time(o.src.mode, lng);
                    return 1'b1;
                end
                o.kind = K_MOVE;
                if (!get_ea(w, pc, o.n, t3, rx, o.size, o.dst, AM_DATA_ALT))
                begin
                    return 1'b0;
                end
                o.cycles = 8'd4 + ea_time(o.src.mode, lng) +
                           ea_time((o.dst.mode == EM_PREDEC) ? EM_IND : o.dst.mode, lng);
                return 1'b1;
            end
            4'h4:
            begin
                if ((op & 16'hF1C0) == 16'h41C0)
                begin
                    o.kind = K_LEA;
                    if (!get_ea(w, pc, o.n, mode, ry, 3'd4, o.src, AM_CONTROL))
                    begin
                        return 1'b0;
                    end
                    o.dst = ea_reg(EM_AREG, rx);
                    o.size = 3'd4;
                    o.cycles = lea_time(o.src.mode);
                    return 1'b1;
                end
                if ((op & 16'hF1C0) == 16'h4180)
                begin
                    o.kind = K_CHK;
                    o.size = 3'd2;
                    if (!get_ea(w, pc, o.n, mode, ry, 3'd2, o.src, AM_DATA))
                    begin
                        return 1'b0;
                    end
                    o.dst = ea_reg(EM_DREG, rx);
                    o.cycles = 8'd10 + ea_time(o.src.mode, 1'b0);
                    o.flags = o.flags | FL_END;
                    return 1'b1;
                end
                unique case (op & 16'hFFC0) inside
                    16'h40C0:
                    begin
                        o.kind = K_MOVE_FROM_SR;
                        o.size = 3'd2;
                        if (!get_ea(w, pc, o.n, mode, ry, 3'd2, o.dst, AM_DATA_ALT))
                        begin
                            return 1'b0;
                        end
                        o.cycles = (o.dst.mode == EM_DREG) ? 8'd6 :
                                   8'd8 + ea_time(o.dst.mode, 1'b0);
                        return 1'b1;
                    end
                    16'h44C0, 16'h46C0:
                    begin
                        f = op[9];
                        o.kind = f ? K_MOVE_TO_SR : K_MOVE_TO_CCR;
                        o.size = 3'd2;
                        if (!get_ea(w, pc, o.n, mode, ry, 3'd2, o.src, AM_DATA))
                        begin
                            return 1'b0;
                        end
                        o.cycles = 8'd12 + ea_time(o.src.mode, 1'b0);
                        o.flags = o.flags | FL_END | (f ? FL_PRIV : 9'd0);
                        return 1'b1;
                    end
                    16'h4800:
                    begin
                        o.kind = K_NBCD;
                        o.size = 3'd1;
                        if (!get_ea(w, pc, o.n, mode, ry, 3'd1, o.dst, AM_DATA_ALT))
                        begin
                            return 1'b0;
                        end
                        o.cycles = (o.dst.mode == EM_DREG) ? 8'd6 :
                                   8'd8 + ea_time(o.dst.mode, 1'b0);
                        return 1'b1;
                    end
                    16'h4840:
                    begin
                        o.size = 3'd4;
                        if (mode == 3'd0)
                        begin
                            o.kind = K_SWAP;
                            o.dst = ea_reg(EM_DREG, ry);
                            o.cycles = 8'd4;
                            return 1'b1;
                        end
                        o.kind = K_PEA;
                        if (!get_ea(w, pc, o.n, mode, ry, 3'd4, o.src, AM_CONTROL))
                        begin
                            return 1'b0;
                        end
                        o.cycles = lea_time(o.src.mode) + 8'd8;
                        return 1'b1;
                    end
                    16'h4880, 16'h48C0:
                    begin
                        o.size = op[6] ? 3'd4 : 3'd2;
                        if (mode == 3'd0)
                        begin
                            o.kind = K_EXT;
                            o.dst = ea_reg(EM_DREG, ry);
                            o.cycles = 8'd4;
                            return 1'b1;
                        end
                        o.kind = K_MOVEM_RM;
                        o.imm = {16'd0, rd_w(w, o.n)};
                        if (!get_ea(w, pc, o.n, mode, ry, o.size, o.dst,
                                    AM_CTRL_ALT | AM_PREDEC))
                        begin
                            return 1'b0;
                        end
                        cnt = popcnt16(o.imm[15:0]);
                        tm = o.dst.mode;
                        bc = (tm == EM_DISP || tm == EM_ABSW) ? 8'd12 :
                             (tm == EM_INDEX) ? 8'd14 : (tm == EM_ABSL) ? 8'd16 : 8'd8;
                        per = (o.size == 3'd4) ? {cnt, 3'b000} : {1'b0, cnt, 2'b00};
                        o.cycles = bc + per;
                        return 1'b1;
                    end
                    16'h4AC0:
                    begin
                        if (op == 16'h4AFC)
                        begin
                            o.kind = K_ILLEGAL;
                            o.flags = o.flags | FL_BRANCH | FL_NOFALL | FL_END;
                            o.cycles = 8'd4;
                            return 1'b1;
                        end
                        o.kind = K_TAS;
                        o.size = 3'd1;
                        if (!get_ea(w, pc, o.n, mode, ry, 3'd1, o.dst, AM_DATA_ALT))
                        begin
                            return 1'b0;
                        end
                        o.cycles = (o.dst.mode == EM_DREG) ? 8'd4 :
                                   8'd14 + ea_time(o.dst.mode, 1'b0);
                        return 1'b1;
                    end
                    16'h4C80, 16'h4CC0:
                    begin
                        o.kind = K_MOVEM_MR;
                        o.size = op[6] ? 3'd4 : 3'd2;
                        o.imm = {16'd0, rd_w(w, o.n)};
                        if (!get_ea(w, pc, o.n, mode, ry, o.size, o.src,
                                    AM_CONTROL | AM_POSTINC))
                        begin
                            return 1'b0;
                        end
                        cnt = popcnt16(o.imm[15:0]);
                        tm = o.src.mode;
                        bc = (tm == EM_DISP || tm == EM_ABSW || tm == EM_PCDISP) ? 8'd16 :
                             (tm == EM_INDEX || tm == EM_PCINDEX) ? 8'd18 :
                             (tm == EM_ABSL) ? 8'd20 : 8'd12;
                        per = (o.size == 3'd4) ? {cnt, 3'b000} : {1'b0, cnt, 2'b00};
                        o.cycles = bc + per;
                        return 1'b1;
                    end
                    16'h4E80, 16'h4EC0:
                    begin
                        f = !op[6];
                        o.kind = f ? K_JSR : K_JMP;
                        if (!get_ea(w, pc, o.n, mode, ry, 3'd4, o.src, AM_CONTROL))
                        begin
                            return 1'b0;
                        end
                        o.flags = o.flags | FL_BRANCH | (f ? FL_CALL : FL_NOFALL);
                        tm = o.src.mode;
                        if (tm == EM_ABSW || tm == EM_ABSL || tm == EM_PCDISP)
                        begin
                            o.target = o.src.value;
                        end
                        else
                        begin
                            o.flags = o.flags | FL_INDIRECT;
                        end
                        o.cycles = jmp_time(tm) + (f ? 8'd8 : 8'd0);
                        return 1'b1;
                    end
                    default: ;
                endcase
                if ((op & 16'hFFF0) == 16'h4E40)
                begin
                    o.kind = K_TRAP;
                    o.imm = {28'd0, op[3:0]};
                    o.cycles = 8'd4;
                    o.flags = o.flags | FL_END | FL_BRANCH | FL_NOFALL | FL_INDIRECT;
                    return 1'b1;
                end
                if ((op & 16'hFFF8) == 16'h4E50)
                begin
                    o.kind = K_LINK;
                    o.rg = ry;
                    o.imm = sx16(rd_w(w, o.n));
                    o.cycles = 8'd16;
                    return 1'b1;
                end
                if ((op & 16'hFFF8) == 16'h4E58)
                begin
                    o.kind = K_UNLK;
                    o.rg = ry;
                    o.cycles = 8'd12;
                    return 1'b1;
                end
                if ((op & 16'hFFF0) == 16'h4E60)
                begin
                    o.kind = op[3] ? K_MOVE_FROM_USP : K_MOVE_TO_USP;
                    o.rg = ry;
                    o.cycles = 8'd4;
                    o.flags = o.flags | FL_PRIV;
                    return 1'b1;
                end
                unique case (op)
                    16'h4E70:
                    begin
                        o.kind = K_RESET;
                        o.cycles = 8'd132;
                        o.flags = o.flags | FL_PRIV | FL_END;
                        return 1'b1;
                    end
                    16'h4E71:
                    begin
                        o.kind = K_NOP;
                        o.cycles = 8'd4;
                        return 1'b1;
                    end
                    16'h4E72:
                    begin
                        o.kind = K_STOP;
                        o.imm = {16'd0, rd_w(w, o.n)};
                        o.cycles = 8'd4;
                        o.flags = o.flags | FL_PRIV | FL_END;
                        return 1'b1;
                    end
                    16'h4E73:
                    begin
                        o.kind = K_RTE;
                        o.cycles = 8'd20;
                        o.flags = o.flags | FL_PRIV | FL_BRANCH | FL_RETURN |
                                  FL_INDIRECT | FL_NOFALL;
                        return 1'b1;
                    end
                    16'h4E75:
                    begin
                        o.kind = K_RTS;
                        o.cycles = 8'd16;
                        o.flags = o.flags | FL_BRANCH | FL_RETURN | FL_INDIRECT | FL_NOFALL;
                        return 1'b1;
                    end
                    16'h4E76:
                    begin
                        o.kind = K_TRAPV;
                        o.cycles = 8'd4;
                        o.flags = o.flags | FL_END;
                        return 1'b1;
                    end
                    16'h4E77:
                    begin
                        o.kind = K_RTR;
                        o.cycles = 8'd20;
                        o.flags = o.flags | FL_BRANCH | FL_RETURN | FL_INDIRECT | FL_NOFALL;
                        return 1'b1;
                    end
                    default: ;
                endcase
                unique case (op[15:8])
                    8'h40:   o.kind = K_NEGX;
                    8'h42:   o.kind = K_CLR;
                    8'h44:   o.kind = K_NEG;
                    8'h46:   o.kind = K_NOT;
                    8'h4A:   o.kind = K_TST;
                    default: return 1'b0;
                endcase
                o.size = size2(sz2);
                if (o.size == 3'd0)
                begin
                    return 1'b0;
                end
                if (!get_ea(w, pc, o.n, mode, ry, o.size, o.dst, AM_DATA_ALT))
                begin
                    return 1'b0;
                end
                lng = (o.size == 3'd4);
                if (o.kind == K_TST)
                begin
                    o.cycles = 8'd4 + ea_time(o.dst.mode, lng);
                end
                else if (o.dst.mode == EM_DREG)
                begin
                    o.cycles = lng ? 8'd6 : 8'd4;
                end
                else
                begin
                    o.cycles = (lng ? 8'd12 : 8'd8) + ea_time(o.dst.mode, lng);
                end
                return 1'b1;
            end
            4'h5:
            begin
                if (sz2 == 2'd3)
                begin
                    o.cc = op[11:8];
                    if (mode == 3'd1)
                    begin
                        o.kind = K_DBCC;
                        o.dst = ea_reg(EM_DREG, ry);
                        base = rd_cur(pc, o.n);
                        o.target = base + sx16(rd_w(w, o.n));
                        o.flags = o.flags | FL_BRANCH | FL_COND;
                        o.cycles = 8'd10;
                        return 1'b1;
                    end
                    o.kind = K_SCC;
                    o.size = 3'd1;
                    if (!get_ea(w, pc, o.n, mode, ry, 3'd1, o.dst, AM_DATA_ALT))
                    begin
                        return 1'b0;
                    end
                    o.cycles = (o.dst.mode == EM_DREG) ? 8'd4 :
                               8'd8 + ea_time(o.dst.mode, 1'b0);
                    return 1'b1;
                end
                o.kind = op[8] ? K_SUBQ : K_ADDQ;
                o.size = size2(sz2);
                o.src = ea_imm((rx == 3'd0) ? 32'd8 : {29'd0, rx});
                if (!get_ea(w, pc, o.n, mode, ry, o.size, o.dst, AM_ALTER))
                begin
                    return 1'b0;
                end
                if (o.dst.mode == EM_AREG && o.size == 3'd1)
                begin
                    return 1'b0;
                end
                lng = (o.size == 3'd4);
                if (o.dst.mode == EM_DREG)
                begin
                    o.cycles = lng ? 8'd8 : 8'd4;
                end
                else if (o.dst.mode == EM_AREG)
                begin
                    o.cycles = 8'd8;
                end
                else
                begin
                    o.cycles = (lng ? 8'd12 : 8'd8) + ea_time(o.dst.mode, lng);
                end
                return 1'b1;
            end
            4'h6:
            begin
                base = rd_cur(pc, o.n);
                if (op[7:0] == 8'hFF)
                begin
                    return 1'b0;
                end
                ofs = (op[7:0] == 8'h00) ? sx16(rd_w(w, o.n)) : sx8(op[7:0]);
                o.target = base + ofs;
                o.flags = o.flags | FL_BRANCH;
                if (op[11:8] == 4'd0)
                begin
                    o.kind = K_BRA;
                    o.flags = o.flags | FL_NOFALL;
                    o.cycles = 8'd10;
                end
                else if (op[11:8] == 4'd1)
                begin
                    o.kind = K_BSR;
                    o.flags = o.flags | FL_CALL;
                    o.cycles = 8'd18;
                end
                else
                begin
                    o.kind = K_BCC;
                    o.cc = op[11:8];
                    o.flags = o.flags | FL_COND;
                    o.cycles = 8'd10;
                end
                o.size = (op[7:0] == 8'h00) ? 3'd2 : 3'd1;
                return 1'b1;
            end
            4'h7:
            begin
                if (op[8])
                begin
                    return 1'b0;
                end
                o.kind = K_MOVEQ;
                o.size = 3'd4;
                o.src = ea_imm(sx8(op[7:0]));
                o.dst = ea_reg(EM_DREG, rx);
                o.cycles = 8'd4;
                return 1'b1;
            end
            4'h8, 4'hC:
            begin
                f = (hi == 4'hC);
                if (sz2 == 2'd3)
                begin
                    sgn = op[8];
                    o.kind = f ? (sgn ? K_MULS : K_MULU) : (sgn ? K_DIVS : K_DIVU);
                    o.size = 3'd2;
                    if (!get_ea(w, pc, o.n, mode, ry, 3'd2, o.src, AM_DATA))
                    begin
                        return 1'b0;
                    end
                    o.dst = ea_reg(EM_DREG, rx);
                    if (f)
                    begin
                        o.cycles = ea_time(o.src.mode, 1'b0);
                    end
                    else
                    begin
                        o.cycles = (sgn ? 8'd158 : 8'd140) + ea_time(o.src.mode, 1'b0);
                        o.flags = o.flags | FL_END;
                    end
                    return 1'b1;
                end
                if (op[8:4] == 5'b10000)
                begin
                    o.kind = f ? K_ABCD : K_SBCD;
                    o.size = 3'd1;
                    tm = op[3] ? EM_PREDEC : EM_DREG;
                    o.src = ea_reg(tm, ry);
                    o.dst = ea_reg(tm, rx);
                    o.cycles = op[3] ? 8'd18 : 8'd6;
                    return 1'b1;
                end
                if (f && (op[8:3] == 6'h28 || op[8:3] == 6'h29 || op[8:3] == 6'h31))
                begin
                    o.kind = K_EXG;
                    o.size = 3'd4;
                    o.cycles = 8'd6;
                    o.src = ea_reg((op[8:3] == 6'h29) ? EM_AREG : EM_DREG, rx);
                    o.dst = ea_reg((op[8:3] == 6'h28) ? EM_DREG : EM_AREG, ry);
                    return 1'b1;
                end
                o.kind = f ? K_AND : K_OR;
                o.size = size2(sz2);
                lng = (o.size == 3'd4);
                if (op[8])
                begin
                    o.src = ea_reg(EM_DREG, rx);
                    if (!get_ea(w, pc, o.n, mode, ry, o.size, o.dst, AM_MEM_ALT))
                    begin
                        return 1'b0;
                    end
                    o.cycles = (lng ? 8'd12 : 8'd8) + ea_time(o.dst.mode, lng);
                end
                else
                begin
                    if (!get_ea(w, pc, o.n, mode, ry, o.size, o.src, AM_DATA))
                    begin
                        return 1'b0;
                    end
                    o.dst = ea_reg(EM_DREG, rx);
                    tm = o.src.mode;
                    o.cycles = 8'd4 + ea_time(tm, lng) +
                               (lng ? ((tm == EM_DREG || tm == EM_IMM) ? 8'd4 : 8'd2) : 8'd0);
                end
                return 1'b1;
            end
            4'h9, 4'hD:
            begin
                f = (hi == 4'hD);
                if (sz2 == 2'd3)
                begin
                    o.kind = f ? K_ADDA : K_SUBA;
                    o.size = op[8] ? 3'd4 : 3'd2;
                    if (!get_ea(w, pc, o.n, mode, ry, o.size, o.src, AM_ALL))
                    begin
                        return 1'b0;
                    end
                    o.dst = ea_reg(EM_AREG, rx);
                    tm = o.src.mode;
                    lng = (o.size == 3'd4);
                    o.cycles = (lng ? ((tm == EM_DREG || tm == EM_AREG || tm == EM_IMM) ?
                                8'd8 : 8'd6) : 8'd8) + ea_time(tm, lng);
                    return 1'b1;
                end
                o.size = size2(sz2);
                lng = (o.size == 3'd4);
                if (op[8] && op[5:4] == 2'b00)
                begin
                    o.kind = f ? K_ADDX : K_SUBX;
                    tm = op[3] ? EM_PREDEC : EM_DREG;
                    o.src = ea_reg(tm, ry);
                    o.dst = ea_reg(tm, rx);
                    o.cycles = op[3] ? (lng ? 8'd30 : 8'd18) : (lng ? 8'd8 : 8'd4);
                    return 1'b1;
                end
                o.kind = f ? K_ADD : K_SUB;
                if (op[8])
                begin
                    o.src = ea_reg(EM_DREG, rx);
                    if (!get_ea(w, pc, o.n, mode, ry, o.size, o.dst, AM_MEM_ALT))
                    begin
                        return 1'b0;
                    end
                    o.cycles = (lng ? 8'd12 : 8'd8) + ea_time(o.dst.mode, lng);
                end
                else
                begin
                    if (!get_ea(w, pc, o.n, mode, ry, o.size, o.src,
                                (o.size == 3'd1) ? AM_DATA : AM_ALL))
                    begin
                        return 1'b0;
                    end
                    o.dst = ea_reg(EM_DREG, rx);
                    tm = o.src.mode;
                    o.cycles = 8'd4 + ea_time(tm, lng) +
                               (lng ? ((tm == EM_DREG || tm == EM_AREG || tm == EM_IMM) ?
                                8'd4 : 8'd2) : 8'd0);
                end
                return 1'b1;
            end
            4'hB:
            begin
                if (sz2 == 2'd3)
                begin
                    o.kind = K_CMPA;
                    o.size = op[8] ? 3'd4 : 3'd2;
                    if (!get_ea(w, pc, o.n, mode, ry, o.size, o.src, AM_ALL))
                    begin
                        return 1'b0;
                    end
                    o.dst = ea_reg(EM_AREG, rx);
                    o.cycles = 8'd6 + ea_time(o.src.mode, o.size == 3'd4);
                    return 1'b1;
                end
                o.size = size2(sz2);
                lng = (o.size == 3'd4);
                if (op[8])
                begin
                    if (mode == 3'd1)
                    begin
                        o.kind = K_CMPM;
                        o.src = ea_reg(EM_POSTINC, ry);
                        o.dst = ea_reg(EM_POSTINC, rx);
                        o.cycles = lng ? 8'd20 : 8'd12;
                        return 1'b1;
                    end
                    o.kind = K_EOR;
                    o.src = ea_reg(EM_DREG, rx);
                    if (!get_ea(w, pc, o.n, mode, ry, o.size, o.dst, AM_DATA_ALT))
                    begin
                        return 1'b0;
                    end
                    o.cycles = (o.dst.mode == EM_DREG) ? (lng ? 8'd8 : 8'd4) :
                               (lng ? 8'd12 : 8'd8) + ea_time(o.dst.mode, lng);
                    return 1'b1;
                end
                o.kind = K_CMP;
                if (!get_ea(w, pc, o.n, mode, ry, o.size, o.src,
                            (o.size == 3'd1) ? AM_DATA : AM_ALL))
                begin
                    return 1'b0;
                end
                o.dst = ea_reg(EM_DREG, rx);
                o.cycles = (lng ? 8'd6 : 8'd4) + ea_time(o.src.mode, lng);
                return 1'b1;
            end
            4'hE:
            begin
                f = op[8];
                if (sz2 == 2'd3)
                begin
                    if (rx[2])
                    begin
                        return 1'b0;
                    end
                    o.kind = shift_op(f, rx[1:0]);
                    o.size = 3'd2;
                    o.src = ea_imm(32'd1);
                    if (!get_ea(w, pc, o.n, mode, ry, 3'd2, o.dst, AM_MEM_ALT))
                    begin
                        return 1'b0;
                    end
                    o.cycles = 8'd8 + ea_time(o.dst.mode, 1'b0);
                    return 1'b1;
                end
                o.kind = shift_op(f, op[4:3]);
                o.size = size2(sz2);
                if (op[5])
                begin
                    o.src = ea_reg(EM_DREG, rx);
                end
                else
                begin
                    o.src = ea_imm((rx == 3'd0) ? 32'd8 : {29'd0, rx});
                end
                o.dst = ea_reg(EM_DREG, ry);
                o.cycles = (o.size == 3'd4) ? 8'd8 : 8'd6;
                return 1'b1;
            end
            default:
            begin
                // line a and line f traps
                o.kind = (hi == 4'hA) ? K_LINE_A : K_LINE_F;
                o.cycles = 8'd4;
                o.flags = o.flags | FL_INVALID;
                return 1'b1;
            end
        endcase
    endfunction

    dec_t d;
    logic ok;

    always_comb
    begin
        d = '0;
        ok = dec_insn(insn, d);
        if (!ok)
        begin
            d = '0;
            d.flags = FL_INVALID;
            d.cycles = 8'd4;
        end
        else if (d.kind != K_ILLEGAL && d.kind != K_LINE_A && d.kind != K_LINE_F)
        begin
            d.flags = d.flags | FL_OK;
        end
    end

    assign res.op_kind = d.kind;
    assign res.op_size = d.size;
    assign res.src_desc = {d.src.disp, d.src.xlong, d.src.xreg, d.src.rg, d.src.mode};
    assign res.src_value = d.src.value;
    assign res.dst_desc = {d.dst.disp, d.dst.xlong, d.dst.xreg, d.dst.rg, d.dst.mode};
    assign res.dst_value = d.dst.value;
    assign res.imm_value = d.imm;
    assign res.branch_target = d.target;
    assign res.reg_and_cond = {d.cc, d.rg};
    assign res.flag_bits = d.flags;
    assign res.cycle_count = d.cycles;
    assign res.insn_length = {d.n[2:0], 1'b0} + 4'd2;

endmodule

// ===== hw/rtl/m68000_instruction_decoder.sv =====
// 68000 instruction decoder
//
// input beat: raise start with insn holding the opcode address and the
// opcode word plus four following words; a beat is taken on any edge with
// start high and busy low. busy is always low, so one beat per clock.
// output beat: done pulses for one cycle with result holding the decoded
// instruction (operation, size, both operands, immediate, branch target,
// register and condition, flags, base cycles and length).
// the opcode is registered, decoded in one pass of logic, and the result
// registered. throughput is one instruction per clock, fixed by the single
// decode pass between the two registers.
// there is no state between instructions. reset clears the valid bits, so
// no done pulse follows reset until a new beat comes in.
// the receiver cannot stall: each result is shown for exactly one cycle.
`include "m68000_instruction_decoder_defines.svh"

module m68000_instruction_decoder (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  m68k_dec_pkg::dec_in_t  insn,
    output logic                   done,
    output m68k_dec_pkg::dec_out_t result
);
    import m68k_dec_pkg::*;

    logic     in_valid_reg;
    logic     in_valid_next;
    dec_in_t  in_reg;
    logic     done_reg;
    dec_out_t res_reg;
    dec_out_t res_next;

    assign busy = 1'b0;
    assign in_valid_next = start && !busy;

    m68k_dec_core u_core (
        .insn (in_reg),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_next)
        begin
            in_reg <= insn;
        end
        if (in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign done = done_reg;
    assign result = res_reg;

    `DEC_ASSERT_NEXT(a_accept_to_decode, start && !busy, in_valid_reg)
    `DEC_ASSERT_NEXT(a_decode_to_done, in_valid_reg, done)
    `DEC_ASSERT_NOW(a_done_has_source, !done || $past(in_valid_reg))
    `DEC_ASSERT_NOW(a_invalid_shape, !done || result.op_kind != K_INVALID || (result.insn_length == 4'd2 && result.cycle_count == 8'd4 && result.flag_bits == FL_INVALID))

endmodule

// ===== test/m68000_instruction_decoder_test.sv =====
`default_nettype none

module m68000_instruction_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import m68k_dec_pkg::*;

    localparam int unsigned RANDOM_INSNS = 1300;
    localparam int unsigned CALM_TAIL = 200;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 6;

    typedef struct {
        logic [3:0]  mode;
        logic [2:0]  rg;
        logic [3:0]  xreg;
        logic        xlong;
        logic [15:0] disp;
        logic [31:0] value;
    } operand_t;

    class insn_scoreboard;
        dec_out_t    pending_decodes[$];
        int unsigned errors;

        logic [31:0] pc;
        logic [15:0] ext[4];
        int unsigned taken;
        logic [6:0]  kind;
        int unsigned size, imm, target, rg, cc, flags, cycles;
        operand_t    src, dst;

        function logic [31:0] sx16(logic [31:0] v);
            return {{16{v[15]}}, v[15:0]};
        endfunction

        function logic [31:0] sx8(logic [31:0] v);
            return {{24{v[7]}}, v[7:0]};
        endfunction

        function logic [31:0] cur_addr();
            return pc + 32'd2 + 32'd2 * taken;
        endfunction

        function logic [31:0] next_word();
            logic [31:0] v;
            v = taken < 4 ? {16'h0, ext[taken]} : 32'h0;
            if (taken < 8) taken++;
            return v;
        endfunction

        function logic [31:0] next_long();
            logic [31:0] h;
            h = next_word();
            return {h[15:0], next_word()[15:0]};
        endfunction

        function int unsigned size2(int unsigned s);
            return s == 0 ? 1 : s == 1 ? 2 : s == 2 ? 4 : 0;
        endfunction

        function operand_t reg_operand(logic [3:0] m, int unsigned r);
            operand_t e;
            e = '{default: '0};
            e.mode = m;
            e.rg = r[2:0];
            return e;
        endfunction

        function operand_t imm_operand(logic [31:0] v);
            operand_t e;
            e = '{default: '0};
            e.mode = EM_IMM;
            e.value = v;
            return e;
        endfunction

        function int unsigned ea_time(logic [3:0] m, bit lng);
            case (m)
                EM_IND, EM_POSTINC, EM_IMM: return lng ? 8 : 4;
                EM_PREDEC: return lng ? 10 : 6;
                EM_DISP, EM_ABSW, EM_PCDISP: return lng ? 12 : 8;
                EM_INDEX, EM_PCINDEX: return lng ? 14 : 10;
                EM_ABSL: return lng ? 16 : 12;
                default: return 0;
            endcase
        endfunction

        function int unsigned lea_time(logic [3:0] m);
            case (m)
                EM_DISP, EM_ABSW, EM_PCDISP: return 8;
                EM_INDEX, EM_PCINDEX, EM_ABSL: return 12;
                default: return 4;
            endcase
        endfunction

        function int unsigned jmp_time(logic [3:0] m);
            case (m)
                EM_DISP, EM_ABSW, EM_PCDISP: return 10;
                EM_INDEX, EM_PCINDEX: return 14;
                EM_ABSL: return 12;
                default: return 8;
            endcase
        endfunction

        function bit fetch_operand(int unsigned mode, int unsigned regn, int unsigned sz,
                                   output operand_t e, input logic [15:0] allowed);
            operand_t t;
            logic [31:0] x, b;
            t = '{default: '0};
            t.rg = regn[2:0];
            e = t;
            case (mode)
                0: t.mode = EM_DREG;
                1: t.mode = EM_AREG;
                2: t.mode = EM_IND;
                3: t.mode = EM_POSTINC;
                4: t.mode = EM_PREDEC;
                5: begin t.mode = EM_DISP; t.disp = next_word(); end
                6:
                begin
                    t.mode = EM_INDEX;
                    x = next_word();
                    t.xreg = x[15:12];
                    t.xlong = x[11];
                    t.disp = sx8(x);
                    e = t;
                    if (x[10:8] != 0) return 0;
                end
                default:
                    case (regn)
                        0: begin t.mode = EM_ABSW; t.value = sx16(next_word()); end
                        1: begin t.mode = EM_ABSL; t.value = next_long(); end
                        2:
                        begin
                            t.mode = EM_PCDISP;
                            b = cur_addr();
                            x = next_word();
                            t.disp = x[15:0];
                            t.value = b + sx16(x);
                        end
                        3:
                        begin
                            t.mode = EM_PCINDEX;
                            b = cur_addr();
                            x = next_word();
                            t.xreg = x[15:12];
                            t.xlong = x[11];
                            t.disp = sx8(x);
                            t.value = b + sx8(x);
                            e = t;
                            if (x[10:8] != 0) return 0;
                        end
                        4:
                        begin
                            t.mode = EM_IMM;
                            if (sz == 1) t.value = next_word() & 32'hFF;
                            else if (sz == 2) t.value = next_word();
                            else t.value = next_long();
                        end
                        default: return 0;
                    endcase
            endcase
            e = t;
            return allowed[t.mode];
        endfunction

        function bit status_imm(logic [6:0] k, bit priv);
            logic [31:0] w;
            w = next_word();
            kind = k;
            imm = priv ? w : (w & 32'hFF);
            cycles = 20;
            flags |= FL_END | (priv ? FL_PRIV : 9'h0);
            return 1;
        endfunction

        function bit decode_opcode(logic [15:0] op);
            int unsigned hi, rx, ry, md, sz2, t, n, base;
            logic [31:0] w, b;
            logic [15:0] allowed;
            bit lng, f, sgn;
            hi = op[15:12];
            rx = op[11:9];
            ry = op[2:0];
            md = op[5:3];
            sz2 = op[7:6];
            case (hi)
                0:
                begin
                    case (op)
                        16'h003C: return status_imm(K_ORI_CCR, 0);
                        16'h007C: return status_imm(K_ORI_SR, 1);
                        16'h023C: return status_imm(K_ANDI_CCR, 0);
                        16'h027C: return status_imm(K_ANDI_SR, 1);
                        16'h0A3C: return status_imm(K_EORI_CCR, 0);
                        16'h0A7C: return status_imm(K_EORI_SR, 1);
                        default: ;
                    endcase
                    if (op[8]) begin
                        if (md == 1) begin
                            size = sz2[0] ? 4 : 2;
                            kind = sz2[1] ? K_MOVEP_RM : K_MOVEP_MR;
                            rg = rx;
                            dst = reg_operand(EM_DISP, ry);
                            dst.disp = next_word();
                            cycles = size == 4 ? 24 : 16;
                            return 1;
                        end
                        kind = K_BTST + sz2;
                        src = reg_operand(EM_DREG, rx);
                        if (!fetch_operand(md, ry, 1, dst,
                                           kind == K_BTST ? AM_DATA : AM_DATA_ALT)) return 0;
                        size = dst.mode == EM_DREG ? 4 : 1;
                        if (dst.mode == EM_DREG)
                            cycles = kind == K_BTST ? 6 : kind == K_BCLR ? 10 : 8;
                        else
                            cycles = (kind == K_BTST ? 4 : 8) + ea_time(dst.mode, 0);
                        return 1;
                    end
                    if (rx == 4) begin
                        kind = K_BTST + sz2;
                        w = next_word();
                        if (w[15:8] != 0) return 0;
                        src = imm_operand(w & 32'hFF);
                        allowed = kind == K_BTST ? AM_DATA_NOIMM : AM_DATA_ALT;
                        if (!fetch_operand(md, ry, 1, dst, allowed)) return 0;
                        size = dst.mode == EM_DREG ? 4 : 1;
                        if (dst.mode == EM_DREG)
                            cycles = kind == K_BTST ? 10 : kind == K_BCLR ? 14 : 12;
                        else
                            cycles = (kind == K_BTST ? 8 : 12) + ea_time(dst.mode, 0);
                        return 1;
                    end
                    case (rx)
                        0: kind = K_ORI;
                        1: kind = K_ANDI;
                        2: kind = K_SUBI;
                        3: kind = K_ADDI;
                        5: kind = K_EORI;
                        6: kind = K_CMPI;
                        default: kind = K_INVALID;
                    endcase
                    if (kind == K_INVALID) return 0;
                    size = size2(sz2);
                    if (size == 0) return 0;
                    src = imm_operand(size == 4 ? next_long() :
                                      size == 2 ? next_word() : (next_word() & 32'hFF));
                    if (!fetch_operand(md, ry, size, dst, AM_DATA_ALT)) return 0;
                    lng = size == 4;
                    if (kind == K_CMPI)
                        cycles = dst.mode == EM_DREG ? (lng ? 14 : 8) :
                                 (lng ? 12 : 8) + ea_time(dst.mode, lng);
                    else
                        cycles = dst.mode == EM_DREG ? (lng ? 16 : 8) :
                                 (lng ? 20 : 12) + ea_time(dst.mode, lng);
                    return 1;
                end
                1, 2, 3:
                begin
                    size = hi == 1 ? 1 : hi == 3 ? 2 : 4;
                    lng = size == 4;
                    if (!fetch_operand(md, ry, size, src, size == 1 ? AM_DATA : AM_ALL))
                        return 0;
                    t = op[8:6];
                    if (t == 1) begin
                        if (size == 1) return 0;
                        kind = K_MOVEA;
                        dst = reg_operand(EM_AREG, rx);
                        cycles = 4 + ea_time(src.mode, lng);
                        return 1;
                    end
                    kind = K_MOVE;
                    if (!fetch_operand(t, rx, size, dst, AM_DATA_ALT)) return 0;
                    cycles = 4 + ea_time(src.mode, lng) +
                             ea_time(dst.mode == EM_PREDEC ? EM_IND : dst.mode, lng);
                    return 1;
                end
                4:
                begin
                    if ((op & 16'hF1C0) == 16'h41C0) begin
                        kind = K_LEA;
                        if (!fetch_operand(md, ry, 4, src, AM_CONTROL)) return 0;
                        dst = reg_operand(EM_AREG, rx);
                        size = 4;
                        cycles = lea_time(src.mode);
                        return 1;
                    end
                    if ((op & 16'hF1C0) == 16'h4180) begin
                        kind = K_CHK;
                        size = 2;
                        if (!fetch_operand(md, ry, 2, src, AM_DATA)) return 0;
                        dst = reg_operand(EM_DREG, rx);
                        cycles = 10 + ea_time(src.mode, 0);
                        flags |= FL_END;
                        return 1;
                    end
                    case (op & 16'hFFC0)
                        16'h40C0:
                        begin
                            kind = K_MOVE_FROM_SR;
                            size = 2;
                            if (!fetch_operand(md, ry, 2, dst, AM_DATA_ALT)) return 0;
                            cycles = dst.mode == EM_DREG ? 6 : 8 + ea_time(dst.mode, 0);
                            return 1;
                        end
                        16'h44C0, 16'h46C0:
                        begin
                            f = op[9];
                            kind = f ? K_MOVE_TO_SR : K_MOVE_TO_CCR;
                            size = 2;
                            if (!fetch_operand(md, ry, 2, src, AM_DATA)) return 0;
                            cycles = 12 + ea_time(src.mode, 0);
                            flags |= FL_END | (f ? FL_PRIV : 9'h0);
                            return 1;
                        end
                        16'h4800:
                        begin
                            kind = K_NBCD;
                            size = 1;
                            if (!fetch_operand(md, ry, 1, dst, AM_DATA_ALT)) return 0;
                            cycles = dst.mode == EM_DREG ? 6 : 8 + ea_time(dst.mode, 0);
                            return 1;
                        end
                        16'h4840:
                        begin
                            size = 4;
                            if (md == 0) begin
                                kind = K_SWAP;
                                dst = reg_operand(EM_DREG, ry);
                                cycles = 4;
                                return 1;
                            end
                            kind = K_PEA;
                            if (!fetch_operand(md, ry, 4, src, AM_CONTROL)) return 0;
                            cycles = lea_time(src.mode) + 8;
                            return 1;
                        end
                        16'h4880, 16'h48C0:
                        begin
                            size = op[6] ? 4 : 2;
                            if (md == 0) begin
                                kind = K_EXT;
                                dst = reg_operand(EM_DREG, ry);
                                cycles = 4;
                                return 1;
                            end
                            kind = K_MOVEM_RM;
                            imm = next_word();
                            if (!fetch_operand(md, ry, size, dst, AM_CTRL_ALT | AM_PREDEC))
                                return 0;
                            n = $countones(imm[15:0]);
                            base = (dst.mode == EM_DISP || dst.mode == EM_ABSW) ? 12 :
                                   dst.mode == EM_INDEX ? 14 : dst.mode == EM_ABSL ? 16 : 8;
                            cycles = base + n * (size == 4 ? 8 : 4);
                            return 1;
                        end
                        16'h4AC0:
                        begin
                            if (op == 16'h4AFC) begin
                                kind = K_ILLEGAL;
                                flags |= FL_BRANCH | FL_NOFALL | FL_END;
                                cycles = 4;
                                return 1;
                            end
                            kind = K_TAS;
                            size = 1;
                            if (!fetch_operand(md, ry, 1, dst, AM_DATA_ALT)) return 0;
                            cycles = dst.mode == EM_DREG ? 4 : 14 + ea_time(dst.mode, 0);
                            return 1;
                        end
                        16'h4C80, 16'h4CC0:
                        begin
                            kind = K_MOVEM_MR;
                            size = op[6] ? 4 : 2;
                            imm = next_word();
                            if (!fetch_operand(md, ry, size, src, AM_CONTROL | AM_POSTINC))
                                return 0;
                            n = $countones(imm[15:0]);
                            t = src.mode;
                            base = (t == EM_DISP || t == EM_ABSW || t == EM_PCDISP) ? 16 :
                                   (t == EM_INDEX || t == EM_PCINDEX) ? 18 :
                                   t == EM_ABSL ? 20 : 12;
                            cycles = base + n * (size == 4 ? 8 : 4);
                            return 1;
                        end
                        16'h4E80, 16'h4EC0:
                        begin
                            f = !op[6];
                            kind = f ? K_JSR : K_JMP;
                            if (!fetch_operand(md, ry, 4, src, AM_CONTROL)) return 0;
                            flags |= FL_BRANCH | (f ? FL_CALL : FL_NOFALL);
                            if (src.mode == EM_ABSW || src.mode == EM_ABSL ||
                                src.mode == EM_PCDISP)
                                target = src.value;
                            else
                                flags |= FL_INDIRECT;
                            cycles = jmp_time(src.mode) + (f ? 8 : 0);
                            return 1;
                        end
                        default: ;
                    endcase
                    if ((op & 16'hFFF0) == 16'h4E40) begin
                        kind = K_TRAP;
                        imm = op[3:0];
                        cycles = 4;
                        flags |= FL_END | FL_BRANCH | FL_NOFALL | FL_INDIRECT;
                        return 1;
                    end
                    if ((op & 16'hFFF8) == 16'h4E50) begin
                        kind = K_LINK;
                        rg = ry;
                        imm = sx16(next_word());
                        cycles = 16;
                        return 1;
                    end
                    if ((op & 16'hFFF8) == 16'h4E58) begin
                        kind = K_UNLK;
                        rg = ry;
                        cycles = 12;
                        return 1;
                    end
                    if ((op & 16'hFFF0) == 16'h4E60) begin
                        kind = op[3] ? K_MOVE_FROM_USP : K_MOVE_TO_USP;
                        rg = ry;
                        cycles = 4;
                        flags |= FL_PRIV;
                        return 1;
                    end
                    case (op)
                        16'h4E70: begin kind = K_RESET; cycles = 132; flags |= FL_PRIV | FL_END;
                            return 1; end
                        16'h4E71: begin kind = K_NOP; cycles = 4; return 1; end
                        16'h4E72: begin kind = K_STOP; imm = next_word(); cycles = 4;
                            flags |= FL_PRIV | FL_END; return 1; end
                        16'h4E73: begin kind = K_RTE; cycles = 20;
                            flags |= FL_PRIV | FL_BRANCH | FL_RETURN | FL_INDIRECT | FL_NOFALL;
                            return 1; end
                        16'h4E75: begin kind = K_RTS; cycles = 16;
                            flags |= FL_BRANCH | FL_RETURN | FL_INDIRECT | FL_NOFALL;
                            return 1; end
                        16'h4E76: begin kind = K_TRAPV; cycles = 4; flags |= FL_END;
                            return 1; end
                        16'h4E77: begin kind = K_RTR; cycles = 20;
                            flags |= FL_BRANCH | FL_RETURN | FL_INDIRECT | FL_NOFALL;
                            return 1; end
                        default: ;
                    endcase
                    case (op[11:8])
                        4'h0: kind = K_NEGX;
                        4'h2: kind = K_CLR;
                        4'h4: kind = K_NEG;
                        4'h6: kind = K_NOT;
                        4'hA: kind = K_TST;
                        default: return 0;
                    endcase
                    size = size2(sz2);
                    if (size == 0) return 0;
                    if (!fetch_operand(md, ry, size, dst, AM_DATA_ALT)) return 0;
                    lng = size == 4;
                    if (kind == K_TST) cycles = 4 + ea_time(dst.mode, lng);
                    else if (dst.mode == EM_DREG) cycles = lng ? 6 : 4;
                    else cycles = (lng ? 12 : 8) + ea_time(dst.mode, lng);
                    return 1;
                end
                5:
                begin
                    if (sz2 == 3) begin
                        cc = op[11:8];
                        if (md == 1) begin
                            kind = K_DBCC;
                            dst = reg_operand(EM_DREG, ry);
                            b = cur_addr();
                            target = b + sx16(next_word());
                            flags |= FL_BRANCH | FL_COND;
                            cycles = 10;
                            return 1;
                        end
                        kind = K_SCC;
                        size = 1;
                        if (!fetch_operand(md, ry, 1, dst, AM_DATA_ALT)) return 0;
                        cycles = dst.mode == EM_DREG ? 4 : 8 + ea_time(dst.mode, 0);
                        return 1;
                    end
                    kind = op[8] ? K_SUBQ : K_ADDQ;
                    size = size2(sz2);
                    src = imm_operand(rx == 0 ? 8 : rx);
                    if (!fetch_operand(md, ry, size, dst, AM_ALTER)) return 0;
                    if (dst.mode == EM_AREG && size == 1) return 0;
                    lng = size == 4;
                    if (dst.mode == EM_DREG) cycles = lng ? 8 : 4;
                    else if (dst.mode == EM_AREG) cycles = 8;
                    else cycles = (lng ? 12 : 8) + ea_time(dst.mode, lng);
                    return 1;
                end
                6:
                begin
                    t = op[11:8];
                    b = cur_addr();
                    if (op[7:0] == 8'hFF) return 0;
                    w = op[7:0] == 0 ? sx16(next_word()) : sx8(op);
                    target = b + w;
                    flags |= FL_BRANCH;
                    if (t == 0) begin kind = K_BRA; flags |= FL_NOFALL; cycles = 10; end
                    else if (t == 1) begin kind = K_BSR; flags |= FL_CALL; cycles = 18; end
                    else begin kind = K_BCC; cc = t; flags |= FL_COND; cycles = 10; end
                    size = op[7:0] == 0 ? 2 : 1;
                    return 1;
                end
                7:
                begin
                    if (op[8]) return 0;
                    kind = K_MOVEQ;
                    size = 4;
                    src = imm_operand(sx8(op));
                    dst = reg_operand(EM_DREG, rx);
                    cycles = 4;
                    return 1;
                end
                8, 12:
                begin
                    f = hi == 12;
                    if (sz2 == 3) begin
                        sgn = op[8];
                        kind = f ? (sgn ? K_MULS : K_MULU) : (sgn ? K_DIVS : K_DIVU);
                        size = 2;
                        if (!fetch_operand(md, ry, 2, src, AM_DATA)) return 0;
                        dst = reg_operand(EM_DREG, rx);
                        if (f) cycles = ea_time(src.mode, 0);
                        else begin
                            cycles = (sgn ? 158 : 140) + ea_time(src.mode, 0);
                            flags |= FL_END;
                        end
                        return 1;
                    end
                    if ((op & 16'h1F0) == 16'h100) begin
                        kind = f ? K_ABCD : K_SBCD;
                        size = 1;
                        src = reg_operand(op[3] ? EM_PREDEC : EM_DREG, ry);
                        dst = reg_operand(op[3] ? EM_PREDEC : EM_DREG, rx);
                        cycles = op[3] ? 18 : 6;
                        return 1;
                    end
                    t = op & 16'h1F8;
                    if (f && (t == 'h140 || t == 'h148 || t == 'h188)) begin
                        kind = K_EXG;
                        size = 4;
                        cycles = 6;
                        src = reg_operand(t == 'h148 ? EM_AREG : EM_DREG, rx);
                        dst = reg_operand(t == 'h140 ? EM_DREG : EM_AREG, ry);
                        return 1;
                    end
                    kind = f ? K_AND : K_OR;
                    size = size2(sz2);
                    lng = size == 4;
                    if (op[8]) begin
                        src = reg_operand(EM_DREG, rx);
                        if (!fetch_operand(md, ry, size, dst, AM_MEM_ALT)) return 0;
                        cycles = (lng ? 12 : 8) + ea_time(dst.mode, lng);
                    end
                    else begin
                        if (!fetch_operand(md, ry, size, src, AM_DATA)) return 0;
                        dst = reg_operand(EM_DREG, rx);
                        cycles = 4 + ea_time(src.mode, lng) + (lng ?
                            ((src.mode == EM_DREG || src.mode == EM_IMM) ? 4 : 2) : 0);
                    end
                    return 1;
                end
                9, 13:
                begin
                    f = hi == 13;
                    if (sz2 == 3) begin
                        kind = f ? K_ADDA : K_SUBA;
                        size = op[8] ? 4 : 2;
                        if (!fetch_operand(md, ry, size, src, AM_ALL)) return 0;
                        dst = reg_operand(EM_AREG, rx);
                        t = src.mode;
                        lng = size == 4;
                        cycles = (lng ? ((t == EM_DREG || t == EM_AREG || t == EM_IMM) ? 8 : 6)
                                  : 8) + ea_time(src.mode, lng);
                        return 1;
                    end
                    size = size2(sz2);
                    lng = size == 4;
                    if ((op & 16'h130) == 16'h100) begin
                        kind = f ? K_ADDX : K_SUBX;
                        src = reg_operand(op[3] ? EM_PREDEC : EM_DREG, ry);
                        dst = reg_operand(op[3] ? EM_PREDEC : EM_DREG, rx);
                        cycles = op[3] ? (lng ? 30 : 18) : (lng ? 8 : 4);
                        return 1;
                    end
                    kind = f ? K_ADD : K_SUB;
                    if (op[8]) begin
                        src = reg_operand(EM_DREG, rx);
                        if (!fetch_operand(md, ry, size, dst, AM_MEM_ALT)) return 0;
                        cycles = (lng ? 12 : 8) + ea_time(dst.mode, lng);
                    end
                    else begin
                        if (!fetch_operand(md, ry, size, src, size == 1 ? AM_DATA : AM_ALL))
                            return 0;
                        dst = reg_operand(EM_DREG, rx);
                        t = src.mode;
                        cycles = 4 + ea_time(src.mode, lng) + (lng ?
                            ((t == EM_DREG || t == EM_AREG || t == EM_IMM) ? 4 : 2) : 0);
                    end
                    return 1;
                end
                11:
                begin
                    if (sz2 == 3) begin
                        kind = K_CMPA;
                        size = op[8] ? 4 : 2;
                        if (!fetch_operand(md, ry, size, src, AM_ALL)) return 0;
                        dst = reg_operand(EM_AREG, rx);
                        cycles = 6 + ea_time(src.mode, size == 4);
                        return 1;
                    end
                    size = size2(sz2);
                    lng = size == 4;
                    if (op[8]) begin
                        if (md == 1) begin
                            kind = K_CMPM;
                            src = reg_operand(EM_POSTINC, ry);
                            dst = reg_operand(EM_POSTINC, rx);
                            cycles = lng ? 20 : 12;
                            return 1;
                        end
                        kind = K_EOR;
                        src = reg_operand(EM_DREG, rx);
                        if (!fetch_operand(md, ry, size, dst, AM_DATA_ALT)) return 0;
                        cycles = dst.mode == EM_DREG ? (lng ? 8 : 4) :
                                 (lng ? 12 : 8) + ea_time(dst.mode, lng);
                        return 1;
                    end
                    kind = K_CMP;
                    if (!fetch_operand(md, ry, size, src, size == 1 ? AM_DATA : AM_ALL))
                        return 0;
                    dst = reg_operand(EM_DREG, rx);
                    cycles = (lng ? 6 : 4) + ea_time(src.mode, lng);
                    return 1;
                end
                14:
                begin
                    f = op[8];
                    if (sz2 == 3) begin
                        if (rx > 3) return 0;
                        kind = f ? K_ASL + rx : K_ASR + rx;
                        size = 2;
                        src = imm_operand(1);
                        if (!fetch_operand(md, ry, 2, dst, AM_MEM_ALT)) return 0;
                        cycles = 8 + ea_time(dst.mode, 0);
                        return 1;
                    end
                    t = op[4:3];
                    kind = f ? K_ASL + t : K_ASR + t;
                    size = size2(sz2);
                    if (op[5]) src = reg_operand(EM_DREG, rx);
                    else src = imm_operand(rx == 0 ? 8 : rx);
                    dst = reg_operand(EM_DREG, ry);
                    cycles = size == 4 ? 8 : 6;
                    return 1;
                end
                default:
                begin
                    kind = hi == 10 ? K_LINE_A : K_LINE_F;
                    cycles = 4;
                    flags |= FL_BRANCH | FL_NOFALL | FL_END | FL_INDIRECT;
                    return 1;
                end
            endcase
        endfunction

        function logic [27:0] pack_operand(operand_t e);
            return {e.disp, e.xlong, e.xreg, e.rg, e.mode};
        endfunction

        function dec_out_t predict_decode(dec_in_t d);
            dec_out_t r;
            bit ok;
            pc = d.instr_address;
            ext[0] = d.word_one;
            ext[1] = d.word_two;
            ext[2] = d.word_three;
            ext[3] = d.word_four;
            taken = 0;
            kind = K_INVALID;
            {size, imm, target, rg, cc, flags, cycles} = '0;
            src = '{default: '0};
            dst = '{default: '0};
            ok = decode_opcode(d.word_zero);
            if (!ok) begin
                kind = K_INVALID;
                {size, imm, target, rg, cc} = '0;
                src = '{default: '0};
                dst = '{default: '0};
                flags = FL_INVALID;
                cycles = 4;
                taken = 0;
            end
            else if (kind != K_ILLEGAL && kind != K_LINE_A && kind != K_LINE_F) begin
                flags |= FL_OK;
            end
            r.op_kind = kind;
            r.op_size = size[2:0];
            r.src_desc = pack_operand(src);
            r.src_value = src.value;
            r.dst_desc = pack_operand(dst);
            r.dst_value = dst.value;
            r.imm_value = imm;
            r.branch_target = target;
            r.reg_and_cond = {cc[3:0], rg[2:0]};
            r.flag_bits = flags[8:0];
            r.cycle_count = cycles[7:0];
            r.insn_length = 4'(2 + 2 * taken);
            return r;
        endfunction

        function void note_insn(dec_in_t d);
            pending_decodes.push_back(predict_decode(d));
        endfunction

        task report(string field, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("%0t: %s got %h, expected %h", $realtime, field, got, want);
        endtask

        task compare(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want) report(field, got, want);
        endtask

        task check_result(dec_out_t got);
            dec_out_t want;
            if (pending_decodes.size() == 0) begin
                report("unexpected beat", 0, 0);
                return;
            end
            want = pending_decodes.pop_front();
            compare("op_kind", got.op_kind, want.op_kind);
            compare("op_size", got.op_size, want.op_size);
            compare("src_desc", got.src_desc, want.src_desc);
            compare("src_value", got.src_value, want.src_value);
            compare("dst_desc", got.dst_desc, want.dst_desc);
            compare("dst_value", got.dst_value, want.dst_value);
            compare("imm_value", got.imm_value, want.imm_value);
            compare("branch_target", got.branch_target, want.branch_target);
            compare("reg_and_cond", got.reg_and_cond, want.reg_and_cond);
            compare("flag_bits", got.flag_bits, want.flag_bits);
            compare("cycle_count", got.cycle_count, want.cycle_count);
            compare("insn_length", got.insn_length, want.insn_length);
        endtask
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     done;
    dec_in_t  insn;
    dec_out_t result;

    insn_scoreboard decodes;
    int unsigned    quiet_cycles;

    m68000_instruction_decoder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .insn   (insn),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy) decodes.note_insn(insn);
        if (rst_n && done) decodes.check_result(result);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function logic [15:0] ext_word();
        logic [15:0] w;
        w = $urandom;
        case ($urandom_range(0, 7))
            0, 1, 2: w[10:8] = 3'b000;
            3, 4: w[15:8] = 8'h00;
            5: w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: ;
        endcase
        return w;
    endfunction

    function logic [15:0] random_opcode();
        logic [15:0] op;
        op = $urandom;
        case ($urandom_range(0, 9))
            0: op = 16'h4E70 | 16'($urandom_range(0, 7));
            1: op = {4'h0, 3'($urandom_range(0, 5)), 9'h03C} & 16'h0E7C | 16'h003C;
            2: op[15:12] = 4'h4;
            3: op = {4'h0, 3'b100, op[8:0]};
            4: op[7:0] = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
            5: op[5:0] = {3'b111, 3'($urandom_range(0, 4))};
            default: ;
        endcase
        return op;
    endfunction

    function logic [31:0] random_address();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFE;
            default: return $urandom;
        endcase
    endfunction

    task send_insn(dec_in_t d, bit may_idle);
        int unsigned gap;
        if (may_idle && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        insn <= d;
        forever begin
            @(posedge clk);
            if (!busy) break;
        end
        @(negedge clk);
    endtask

    task send_opcode(logic [15:0] op, logic [15:0] w1);
        dec_in_t d;
        d.instr_address = random_address();
        d.word_zero = op;
        d.word_one = w1;
        d.word_two = ext_word();
        d.word_three = ext_word();
        d.word_four = ext_word();
        send_insn(d, 1'b1);
    endtask

    task wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (decodes.pending_decodes.size() != 0) @(negedge clk);
    endtask

    logic [15:0] directed_ops[] = '{
        16'h003C, 16'h007C, 16'h023C, 16'h027C, 16'h0A3C, 16'h0A7C, 16'h0188,
        16'h4AFC, 16'h4E70, 16'h4E71, 16'h4E72, 16'h4E73, 16'h4E74, 16'h4E75,
        16'h4E76, 16'h4E77, 16'h41FA, 16'h4EB9, 16'h6000, 16'h60FF, 16'h51C8,
        16'h23FC, 16'hA123, 16'hF456, 16'hE0C0
    };

    initial
    begin
        dec_in_t d;
        decodes = new();
        quiet_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        insn = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_ops[i])
            send_opcode(directed_ops[i], i[0] ? 16'hFFFF : 16'h0000);
        // pc-indexed movem whose register mask word has bits 10:8 set
        send_opcode(16'h4CBB, 16'h0700);
        send_opcode(16'h0800, 16'h0100);

        for (int unsigned i = 0; i < RANDOM_INSNS; i++) begin
            if (i == RANDOM_INSNS / 2) wait_drained();
            d.instr_address = random_address();
            d.word_zero = random_opcode();
            d.word_one = ext_word();
            d.word_two = ext_word();
            d.word_three = ext_word();
            d.word_four = ext_word();
            send_insn(d, i < RANDOM_INSNS - CALM_TAIL);
        end
        start <= 1'b0;

        while (decodes.pending_decodes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (decodes.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/m68k_dec_pkg.sv
hw/rtl/m68k_dec_core.sv
hw/rtl/m68000_instruction_decoder.sv
test/m68000_instruction_decoder_test.sv
